// ===== rtl/fssa_pkg.sv =====
package fssa_pkg;

    localparam int SLOTS_DEFAULT = 16;
    localparam int SLOT_W        = 4;
    localparam int STATUS_W      = 2;
    localparam int FREE_COUNT_W  = 5;

    localparam logic MODE_ALLOC  = 1'b0;
    localparam logic MODE_RETURN = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic push;
        logic pop;
        logic pop_load;
        logic fail;
        logic fail_full;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic empty;
        logic full;
        logic out_valid;
    } t_dp_stat;

endpackage

// ===== rtl/fssa_req_if.sv =====
interface fssa_req_if;
    import fssa_pkg::*;

    logic              valid;
    logic              ready;
    logic              mode;
    logic [SLOT_W-1:0] returned_slot;

    modport source (output valid, output mode, output returned_slot, input ready);
    modport sink   (input valid, input mode, input returned_slot, output ready);
endinterface

// ===== rtl/fssa_rsp_if.sv =====
interface fssa_rsp_if;
    import fssa_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [SLOT_W-1:0]       granted_slot;
    logic [STATUS_W-1:0]     status;
    logic [FREE_COUNT_W-1:0] free_count;

    modport source (output valid, output granted_slot, output status, output free_count,
                    input ready);
    modport sink   (input valid, input granted_slot, input status, input free_count,
                    output ready);
endinterface

// ===== rtl/fssa_ram.sv =====
module fssa_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/fssa_ctrl.sv =====
module fssa_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    input  logic               i_req_mode,
    input  logic               i_rsp_ready,
    input  fssa_pkg::t_dp_stat i_stat,
    output logic               o_req_ready,
    output fssa_pkg::t_dp_cmd  o_cmd
);
    import fssa_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   accept;
    logic   out_free;

    assign out_free = !i_stat.out_valid || i_rsp_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.pop) begin
                    n_state = S_READ;
                end
            end
            S_READ:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_req_ready = 1'b0;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                o_req_ready     = out_free;
                o_cmd.push      = accept && (i_req_mode == MODE_RETURN) && !i_stat.full;
                o_cmd.pop       = accept && (i_req_mode == MODE_ALLOC) && !i_stat.empty;
                o_cmd.fail      = accept && (((i_req_mode == MODE_ALLOC) && i_stat.empty) ||
                                             ((i_req_mode == MODE_RETURN) && i_stat.full));
                o_cmd.fail_full = (i_req_mode == MODE_RETURN);
            end
            S_READ: begin
                o_cmd.pop_load = 1'b1;
            end
            default: begin
                o_req_ready = 1'b0;
            end
        endcase
    end

    assign accept = i_req_valid && o_req_ready;

    // read wait always returns to idle in the next cycle
    a_read_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> (r_state == S_IDLE))
        else $error("read state held");

    // the output register must be free while the stack read is in flight
    a_read_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !i_stat.out_valid)
        else $error("result register busy during read");

    // at most one datapath operation per cycle
    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.push, o_cmd.pop, o_cmd.pop_load, o_cmd.fail}))
        else $error("conflicting datapath commands");
endmodule

// ===== rtl/fssa_dp.sv =====
module fssa_dp #(
    parameter int SLOTS = fssa_pkg::SLOTS_DEFAULT,
    parameter int CW    = $clog2(SLOTS + 1),
    parameter int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  fssa_pkg::t_dp_cmd                 i_cmd,
    input  logic [fssa_pkg::SLOT_W-1:0]       i_returned_slot,
    input  logic                              i_rsp_ready,
    output fssa_pkg::t_dp_stat                o_stat,
    output logic                              o_rsp_valid,
    output logic [fssa_pkg::SLOT_W-1:0]       o_granted_slot,
    output logic [fssa_pkg::STATUS_W-1:0]     o_status,
    output logic [fssa_pkg::FREE_COUNT_W-1:0] o_free_count
);
    import fssa_pkg::*;

    localparam logic [CW-1:0] SlotsCount = CW'(SLOTS);

    logic [CW-1:0]           r_count;
    logic [CW-1:0]           r_low;    // lowest count since reset; entries below it are untouched
    logic                    r_use_reset;
    logic [SLOT_W-1:0]       r_reset_val;
    logic                    r_out_valid;
    logic [SLOT_W-1:0]       r_out_slot;
    t_status                 r_out_status;
    logic [FREE_COUNT_W-1:0] r_out_count;

    logic [CW-1:0]     pop_pos;
    logic [SLOT_W-1:0] ram_rdata;
    logic [SLOT_W-1:0] pop_slot;

    assign pop_pos  = r_count - CW'(1);
    assign pop_slot = r_use_reset ? r_reset_val : ram_rdata;

    fssa_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOTS),
        .AW    (AW)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (AW'(r_count)),
        .i_wdata (i_returned_slot),
        .i_raddr (AW'(pop_pos)),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= SlotsCount;
            r_low       <= SlotsCount;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.push) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.pop) begin
                r_count <= pop_pos;
                if (pop_pos < r_low) begin
                    r_low <= pop_pos;
                end
            end
            if (i_cmd.push || i_cmd.fail || i_cmd.pop_load) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pop) begin
            r_use_reset <= (pop_pos < r_low);
            r_reset_val <= SLOT_W'(pop_pos);
        end
        if (i_cmd.push) begin
            r_out_slot   <= '0;
            r_out_status <= ST_DONE;
            r_out_count  <= FREE_COUNT_W'(r_count + CW'(1));
        end else if (i_cmd.fail) begin
            r_out_slot   <= '0;
            r_out_status <= i_cmd.fail_full ? ST_FULL : ST_EMPTY;
            r_out_count  <= FREE_COUNT_W'(r_count);
        end else if (i_cmd.pop_load) begin
            r_out_slot   <= pop_slot;
            r_out_status <= ST_DONE;
            r_out_count  <= FREE_COUNT_W'(r_count);
        end
    end

    assign o_stat.empty     = (r_count == '0);
    assign o_stat.full      = (r_count == SlotsCount);
    assign o_stat.out_valid = r_out_valid;

    assign o_rsp_valid    = r_out_valid;
    assign o_granted_slot = r_out_slot;
    assign o_status       = r_out_status;
    assign o_free_count   = r_out_count;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= SlotsCount)
        else $error("free count out of range");

    a_low_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_low <= r_count)
        else $error("low mark above free count");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |=> (r_count == $past(r_count) + CW'(1)))
        else $error("push did not grow the stack");
endmodule

// ===== rtl/free_slot_stack_allocator_top.sv =====
// free slot stack allocator
// keeps a pool of SLOTS slot indices on a lifo stack of free entries.
// request channel i_req: mode 0 allocates a slot, mode 1 returns
// returned_slot to the pool. response channel o_rsp: one transfer per
// request with granted_slot, status (done, pool empty, stack full) and the
// free count after the request.
// for a return, and for an allocate refused on an empty pool, the response
// is valid the cycle after the request transfer. a granted allocate reads
// the stack memory with a registered read port and loads the response
// register from the read wait state that follows.
// one request is in work at a time; a new request is taken once the
// response register is empty or being drained in the same cycle, so returns
// and refusals go at one request per cycle while the receiver keeps up;
// a granted allocate takes no new request until its stack read is done.
// after reset all SLOTS indices are free with the highest on top; the stack
// memory needs no clearing pass, a low-water mark of the free count tells
// which entries still hold their reset index.
// if the receiver stalls, the response holds and no new request is taken.
module free_slot_stack_allocator_top #(
    parameter int SLOTS = fssa_pkg::SLOTS_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fssa_req_if.sink   i_req,
    fssa_rsp_if.source o_rsp
);
    import fssa_pkg::*;

    localparam int CW = $clog2(SLOTS + 1);
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    fssa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_mode  (i_req.mode),
        .i_rsp_ready (o_rsp.ready),
        .i_stat      (stat),
        .o_req_ready (i_req.ready),
        .o_cmd       (cmd)
    );

    fssa_dp #(
        .SLOTS (SLOTS),
        .CW    (CW),
        .AW    (AW)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_returned_slot (i_req.returned_slot),
        .i_rsp_ready     (o_rsp.ready),
        .o_stat          (stat),
        .o_rsp_valid     (o_rsp.valid),
        .o_granted_slot  (o_rsp.granted_slot),
        .o_status        (o_rsp.status),
        .o_free_count    (o_rsp.free_count)
    );
endmodule
